// File: hdl/rdc_pkg.sv
package rdc_pkg;

	// Field widths of the request and response
	localparam int VAL_W   = 32;
	localparam int BASE_W  = 6;
	localparam int CHAR_W  = 7;
	localparam int DIGIT_W = 6;

	// Digit store geometry
	localparam int STORE_DEPTH = 32;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = SLOT_W + 1;

	// Radix limits
	localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
	localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(36);
	localparam logic [BASE_W-1:0] HEX_BASE = BASE_W'(16);

	// ASCII anchors of the digit table "0-9A-Z"
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h37;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_SHOW,
		ST_ERR
	} rdc_state_t;

	// Status from the divider to the sequencer
	typedef struct packed {
		logic done;
		logic quot_zero;
	} div_stat_t;

	// Map a digit value to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char_f(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < DIGIT_W'(10)) begin
			ch = CHAR_ZERO + CHAR_W'(d);
		end else if (d < MAX_BASE) begin
			ch = CHAR_ALPHA + CHAR_W'(d);
		end else begin
			ch = CHAR_ZERO;
		end
		return ch;
	endfunction

endpackage

// File: hdl/rdc_if.sv
interface rdc_req_if;
	logic                          valid;
	logic                          ready;
	logic [rdc_pkg::VAL_W-1:0]     value;
	logic [rdc_pkg::BASE_W-1:0]    base;

	modport source (output valid, value, base, input ready);
	modport sink   (input valid, value, base, output ready);
endinterface

interface rdc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rdc_pkg::CHAR_W-1:0]    digit_char;
	logic                          last_digit;
	logic                          bad_base;

	modport source (output valid, digit_char, last_digit, bad_base, input ready);
	modport sink   (input valid, digit_char, last_digit, bad_base, output ready);
endinterface

// File: hdl/rdc_divider.sv
// Restoring divider: one quotient bit per cycle through a shared
// compare and subtract unit.
module rdc_divider #(
	parameter int W = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [W-1:0]                   dividend,
	input  logic [rdc_pkg::BASE_W-1:0]     divisor,
	output rdc_pkg::div_stat_t             stat,
	output logic [W-1:0]                   quotient,
	output logic [rdc_pkg::DIGIT_W-1:0]    remainder
);

	localparam int STEP_W = $clog2(W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [W-1:0]                  quo_q;
	logic [rdc_pkg::DIGIT_W-1:0]   rem_q;

	logic [rdc_pkg::DIGIT_W:0]     trial;
	logic [rdc_pkg::DIGIT_W:0]     diff;
	logic                          fits;
	logic [rdc_pkg::DIGIT_W-1:0]   rem_nx;

	// Shift in the next dividend bit and try to subtract the divisor
	always_comb begin
		trial  = {rem_q, quo_q[W-1]};
		diff   = trial - {1'b0, divisor};
		fits   = trial >= {1'b0, divisor};
		rem_nx = fits ? diff[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
	end

	// Sequence the steps and flag completion for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	// Load the operand, then advance quotient and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= rem_nx;
		end
	end

	assign stat.done      = done_q;
	assign stat.quot_zero = (quo_q == '0);
	assign quotient       = quo_q;
	assign remainder      = rem_q;

endmodule

// File: hdl/radix_digit_conversion.sv
// A bad base gives its single response in the cycle after the request is taken.
// A good base runs one division per digit in the shared divider, each on
// N = min(VALUE_BITS, 32) dividend bits, before the first digit is offered.
// Each digit is then emitted by a store read, then a response.
// One request at a time: ready only when idle.
// Reset clears control state; the digit store is not cleared.
module radix_digit_conversion #(
	parameter int VALUE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	rdc_req_if.sink       req,
	rdc_rsp_if.source     rsp
);

	localparam int NB = (VALUE_BITS < rdc_pkg::VAL_W) ? VALUE_BITS : rdc_pkg::VAL_W;

	rdc_pkg::rdc_state_t               state_q;
	rdc_pkg::rdc_state_t               state_nx;
	logic [rdc_pkg::CNT_W-1:0]         cnt_q;
	logic [rdc_pkg::BASE_W-1:0]        base_q;
	logic [rdc_pkg::DIGIT_W-1:0]       rd_q;
	logic [rdc_pkg::DIGIT_W-1:0]       mem [rdc_pkg::STORE_DEPTH];

	rdc_pkg::div_stat_t                div_stat;
	logic [NB-1:0]                     div_quot;
	logic [rdc_pkg::DIGIT_W-1:0]       div_rem;
	logic [NB-1:0]                     div_dividend;
	logic                              div_start;

	logic                              req_bad;
	logic                              req_fire;
	logic                              rsp_fire;
	logic                              last_slot;
	logic                              div_stop;
	logic [rdc_pkg::SLOT_W-1:0]        rd_addr;

	always_comb begin
		req_bad   = (req.base < rdc_pkg::MIN_BASE) || (req.base > rdc_pkg::MAX_BASE);
		req_fire  = req.valid && req.ready;
		rsp_fire  = rsp.valid && rsp.ready;
		last_slot = (cnt_q == rdc_pkg::CNT_W'(rdc_pkg::STORE_DEPTH - 1));
		div_stop  = div_stat.quot_zero || last_slot;
		rd_addr   = rdc_pkg::SLOT_W'(cnt_q - rdc_pkg::CNT_W'(1));
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rdc_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_nx = req_bad ? rdc_pkg::ST_ERR : rdc_pkg::ST_DIV;
				end
			end
			rdc_pkg::ST_DIV: begin
				if (div_stat.done && div_stop) begin
					state_nx = rdc_pkg::ST_READ;
				end
			end
			rdc_pkg::ST_READ: begin
				state_nx = rdc_pkg::ST_SHOW;
			end
			rdc_pkg::ST_SHOW: begin
				if (rsp.ready) begin
					state_nx = (cnt_q == rdc_pkg::CNT_W'(1)) ? rdc_pkg::ST_IDLE
					                                         : rdc_pkg::ST_READ;
				end
			end
			rdc_pkg::ST_ERR: begin
				if (rsp.ready) begin
					state_nx = rdc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = rdc_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req.ready      = 1'b0;
		rsp.valid      = 1'b0;
		rsp.digit_char = rdc_pkg::CHAR_NONE;
		rsp.last_digit = 1'b0;
		rsp.bad_base   = 1'b0;
		div_start      = 1'b0;
		div_dividend   = div_quot;
		case (state_q)
			rdc_pkg::ST_IDLE: begin
				req.ready    = 1'b1;
				div_dividend = req.value[NB-1:0];
				div_start    = req.valid && !req_bad;
			end
			rdc_pkg::ST_DIV: begin
				div_start = div_stat.done && !div_stop;
			end
			rdc_pkg::ST_SHOW: begin
				rsp.valid      = 1'b1;
				rsp.digit_char = rdc_pkg::digit_char_f(rd_q);
				rsp.last_digit = (cnt_q == rdc_pkg::CNT_W'(1));
			end
			rdc_pkg::ST_ERR: begin
				rsp.valid      = 1'b1;
				rsp.last_digit = 1'b1;
				rsp.bad_base   = 1'b1;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// Hold state and the digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (req_fire) begin
				cnt_q <= '0;
			end else if (state_q == rdc_pkg::ST_DIV && div_stat.done) begin
				cnt_q <= cnt_q + rdc_pkg::CNT_W'(1);
			end else if (state_q == rdc_pkg::ST_SHOW && rsp_fire) begin
				cnt_q <= cnt_q - rdc_pkg::CNT_W'(1);
			end
		end
	end

	// Capture the base of the request
	always_ff @(posedge clk) begin
		if (req_fire) begin
			base_q <= req.base;
		end
	end

	// Digit store: write each remainder, read most significant first
	always_ff @(posedge clk) begin
		if (state_q == rdc_pkg::ST_DIV && div_stat.done) begin
			mem[cnt_q[rdc_pkg::SLOT_W-1:0]] <= div_rem;
		end
		if (state_q == rdc_pkg::ST_READ) begin
			rd_q <= mem[rd_addr];
		end
	end

	rdc_divider #(
		.W (NB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (base_q),
		.stat      (div_stat),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// A response is never offered while a new request can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("response valid while request ready");

	// A request with a bad base answers with an error flag in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req_bad) |=> (rsp.valid && rsp.bad_base && rsp.last_digit))
		else $error("bad base not flagged");

	// An error response carries no digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.bad_base) |-> (rsp.digit_char == rdc_pkg::CHAR_NONE))
		else $error("error response carries a digit");

	// The digit count never exceeds the store depth
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rdc_pkg::CNT_W'(rdc_pkg::STORE_DEPTH))
		else $error("digit count overflow");

endmodule

// File: test/rdc_digit_checker.sv
`timescale 1ns / 100ps

module rdc_digit_checker (
	input  logic  clk,
	input  logic  arst_n,
	rdc_req_if    req,
	rdc_rsp_if    rsp,
	output int    mismatch_count,
	output int    digits_owed
);

	localparam logic [rdc_pkg::CHAR_W-1:0] ASCII_ZERO    = 7'h30;
	localparam logic [rdc_pkg::CHAR_W-1:0] ASCII_UPPER_A = 7'h41;

	typedef struct packed {
		logic [rdc_pkg::CHAR_W-1:0] digit_char;
		logic                       last_digit;
		logic                       bad_base;
	} digit_rec_t;

	digit_rec_t owed_digits [$];

	// Queue the digits of value in base, most significant first, or one error record for a bad base
	function automatic void predict_digits(input logic [rdc_pkg::VAL_W-1:0] value,
			input logic [rdc_pkg::BASE_W-1:0] base);
		logic [rdc_pkg::DIGIT_W-1:0] remainders [rdc_pkg::STORE_DEPTH];
		logic [rdc_pkg::VAL_W-1:0]   quotient;
		logic [rdc_pkg::DIGIT_W-1:0] d;
		digit_rec_t                  rec;
		int                          count;

		if (base < rdc_pkg::MIN_BASE || base > rdc_pkg::MAX_BASE) begin
			rec.digit_char = rdc_pkg::CHAR_NONE;
			rec.last_digit = 1'b1;
			rec.bad_base   = 1'b1;
			owed_digits.push_back(rec);
			return;
		end
		quotient = value;
		count    = 0;
		do begin
			remainders[count] = rdc_pkg::DIGIT_W'(quotient % rdc_pkg::VAL_W'(base));
			quotient          = quotient / rdc_pkg::VAL_W'(base);
			count++;
		end while (quotient != '0 && count < rdc_pkg::STORE_DEPTH);
		for (int k = 0; k < count; k++) begin
			d = remainders[count - 1 - k];
			if (d < rdc_pkg::DIGIT_W'(10)) begin
				rec.digit_char = ASCII_ZERO + rdc_pkg::CHAR_W'(d);
			end else begin
				rec.digit_char = ASCII_UPPER_A + rdc_pkg::CHAR_W'(d)
				                 - rdc_pkg::CHAR_W'(10);
			end
			rec.last_digit = (k == count - 1);
			rec.bad_base   = 1'b0;
			owed_digits.push_back(rec);
		end
	endfunction

	// Predict on each accepted request, compare each accepted digit
	always @(posedge clk) begin
		digit_rec_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				predict_digits(req.value, req.base);
			end
			if (rsp.valid && rsp.ready) begin
				if (owed_digits.size() == 0) begin
					$display("%0t: unexpected digit char=%h last=%b bad=%b", $time,
						rsp.digit_char, rsp.last_digit, rsp.bad_base);
					mismatch_count++;
				end else begin
					want = owed_digits.pop_front();
					if (rsp.digit_char !== want.digit_char) begin
						$display("%0t: digit_char expected %h actual %h", $time,
							want.digit_char, rsp.digit_char);
						mismatch_count++;
					end
					if (rsp.last_digit !== want.last_digit) begin
						$display("%0t: last_digit expected %b actual %b", $time,
							want.last_digit, rsp.last_digit);
						mismatch_count++;
					end
					if (rsp.bad_base !== want.bad_base) begin
						$display("%0t: bad_base expected %b actual %b", $time,
							want.bad_base, rsp.bad_base);
						mismatch_count++;
					end
				end
			end
			digits_owed <= owed_digits.size();
		end
	end

endmodule

// File: test/radix_digit_conversion_tb.sv
`timescale 1ns / 100ps

module radix_digit_conversion_tb;

	localparam int DIRECTED_COUNT = 22;
	localparam int RANDOM_COUNT   = 238;
	localparam int TOTAL_COUNT    = DIRECTED_COUNT + RANDOM_COUNT;
	localparam int DRAIN_CYCLES   = 100;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   items_sent;
	int   mismatch_count;
	int   digits_owed;

	rdc_req_if req_ch ();
	rdc_rsp_if rsp_ch ();

	radix_digit_conversion DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rdc_digit_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.digits_owed    (digits_owed)
	);

	always #5 clk = ~clk;

	// Stall the digit output at random
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Set idle rates by progress: sender light then heavy, then no idling
	task automatic set_idle_rates();
		if (items_sent < TOTAL_COUNT / 3) begin
			send_idle_pct = 27;
			recv_idle_pct = 61;
		end else if (items_sent < 2 * TOTAL_COUNT / 3) begin
			send_idle_pct = 61;
			recv_idle_pct = 27;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// Drive one request from a falling edge and hold until accepted
	task automatic send_request(input logic [rdc_pkg::VAL_W-1:0] value,
			input logic [rdc_pkg::BASE_W-1:0] base);
		set_idle_rates();
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.value <= value;
		req_ch.base  <= base;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [rdc_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(1000);
			6:          return '0;
			7:          return rdc_pkg::VAL_W'(1) << $urandom_range(31);
			8:          return (rdc_pkg::VAL_W'(1) << $urandom_range(31))
			                   - rdc_pkg::VAL_W'(1);
			default:    return ~rdc_pkg::VAL_W'($urandom_range(1000));
		endcase
	endfunction

	function automatic logic [rdc_pkg::BASE_W-1:0] pick_base();
		int r;
		r = $urandom_range(99);
		if (r < 10) return rdc_pkg::BASE_W'($urandom_range(63));
		if (r < 20) return rdc_pkg::HEX_BASE;
		if (r < 23) return rdc_pkg::MAX_BASE;
		if (r < 26) return rdc_pkg::MIN_BASE;
		return rdc_pkg::BASE_W'($urandom_range(36, 2));
	endfunction

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.value  = '0;
		req_ch.base   = '0;
		items_sent    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero value, extremes, every digit range and bad bases
		send_request(32'd0, 6'd10);
		send_request(32'd0, rdc_pkg::MIN_BASE);
		send_request(32'd0, rdc_pkg::MAX_BASE);
		send_request(32'hFFFF_FFFF, rdc_pkg::MIN_BASE);
		send_request(32'hFFFF_FFFF, rdc_pkg::HEX_BASE);
		send_request(32'hFFFF_FFFF, rdc_pkg::MAX_BASE);
		send_request(32'hFFFF_FFFF, 6'd10);
		send_request(32'd1, rdc_pkg::MIN_BASE);
		send_request(32'h8000_0000, rdc_pkg::MIN_BASE);
		send_request(32'd35, rdc_pkg::MAX_BASE);
		send_request(32'd36, rdc_pkg::MAX_BASE);
		send_request(32'd34, 6'd35);
		send_request(32'd9, 6'd10);
		send_request(32'd10, rdc_pkg::HEX_BASE);
		send_request(32'hDEAD_BEEF, rdc_pkg::HEX_BASE);
		send_request(32'hAAAA_AAAA, 6'd3);
		send_request(32'h5555_5555, 6'd7);
		send_request(32'd1234, 6'd0);
		send_request(32'd0, 6'd1);
		send_request(32'hFFFF_FFFF, 6'd37);
		send_request(32'd99, 6'd63);
		send_request(32'h0123_4567, 6'd31);

		// Random values and bases
		repeat (RANDOM_COUNT) send_request(pick_value(), pick_base());
		req_ch.valid <= 1'b0;

		// Drain outstanding digits, then watch for strays
		@(posedge clk);
		while (digits_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && digits_owed == 0) begin
			$display("radix_digit_conversion_tb: PASS");
		end else begin
			$display("radix_digit_conversion_tb: FAIL");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("radix_digit_conversion_tb: FAIL");
		$finish;
	end

endmodule
